[hw/rtl/npd_pkg.sv]
// Shared types and constants of the nearest point distance block
`timescale 1ns / 1ps
package npd_pkg;

    localparam int MAX_POINTS_DEF      = 1024;
    localparam int MAX_QUERY_NODES_DEF = 32;
    localparam int COORD_WIDTH_DEF     = 24;

    // sums carry six bits of headroom for up to 64 query nodes
    localparam int SUM_GUARD = 6;

    localparam int APB_AW = 1;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_DIMENSIONS = 1'b0;

    localparam logic [1:0] DIM_2D = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_ADD_TARGET = 2'd1,
        OP_ADD_NODE   = 2'd2,
        OP_FINISH     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_TARGETS = 2'd1,
        ST_NO_NODES   = 2'd2
    } status_t;

endpackage

[hw/rtl/npd_if.sv]
// Request and result channel interfaces
`timescale 1ns / 1ps
interface npd_req_if #(parameter int CW = npd_pkg::COORD_WIDTH_DEF);
    logic             valid;
    logic             ready;
    npd_pkg::opcode_t opcode;
    logic [CW-1:0]    coord_x;
    logic [CW-1:0]    coord_y;
    logic [CW-1:0]    coord_z;

    modport source (output valid, opcode, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, coord_z, output ready);
endinterface

interface npd_rsp_if #(parameter int CW = npd_pkg::COORD_WIDTH_DEF);
    logic             valid;
    logic             ready;
    logic [CW:0]      distance;
    npd_pkg::status_t status;
    logic             overflowed;

    modport source (output valid, distance, status, overflowed, input ready);
    modport sink   (input valid, distance, status, overflowed, output ready);
endinterface

[hw/rtl/npd_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module npd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[hw/rtl/npd_div.sv]
// Iterative signed divider: one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module npd_div #(
    parameter int NW = 30,
    parameter int DW = 6,
    parameter int QW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic [DW-1:0]        divisor,
    output logic                 done,
    output logic signed [QW-1:0] quotient
);
    localparam int SW = $clog2(NW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [NW-1:0] mag_reg, mag_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   rem_sh;
    logic          qbit;
    logic [NW-1:0] quo_signed;

    // shift in the next dividend bit and trial subtract
    always_comb
    begin
        rem_sh     = {rem_reg[DW-1:0], mag_reg[NW-1]};
        qbit       = (rem_sh >= {1'b0, dvs_reg});
        run_next   = run_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            mag_next  = dividend[NW-1] ? (~dividend + 1'b1) : dividend;
            quo_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[NW-1];
        end
        else if (run_reg)
        begin
            mag_next  = {mag_reg[NW-2:0], 1'b0};
            quo_next  = {quo_reg[NW-2:0], qbit};
            rem_next  = qbit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    // restore the sign; the magnitude always fits the coordinate range
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[QW-1:0];
    assign done       = done_reg;

    property p_done_after_run;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(run_reg);
    endproperty
    a_done_after_run: assert property (p_done_after_run)
        else $error("divider done without a running division");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) run_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("divider restarted while busy");

    property p_rem_below_divisor;
        @(posedge clk) disable iff (!rst_n) run_reg |-> (rem_reg < {1'b0, dvs_reg});
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divider remainder out of range");
endmodule

[hw/rtl/npd_sqrt.sv]
// Iterative integer square root, one root bit per cycle
`timescale 1ns / 1ps
module npd_sqrt #(
    parameter int RW = 25
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);
    localparam int SW = $clog2(RW + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [2*RW-1:0] n_reg, n_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            fits;
    logic [RW+2:0]   rem_diff;

    // bring down two radicand bits and test the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg, n_reg[2*RW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        rem_diff  = rem_sh - trial;
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            n_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            n_next    = {n_reg[2*RW-3:0], 2'b00};
            rem_next  = fits ? rem_diff[RW:0] : rem_sh[RW:0];
            root_next = {root_reg[RW-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(RW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    property p_done_after_run;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(run_reg);
    endproperty
    a_done_after_run: assert property (p_done_after_run)
        else $error("square root done without a running pass");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) run_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("square root restarted while busy");

    property p_rem_bound;
        @(posedge clk) disable iff (!rst_n)
            run_reg |-> ({1'b0, rem_reg} <= {1'b0, root_reg, 1'b0});
    endproperty
    a_rem_bound: assert property (p_rem_bound)
        else $error("square root remainder above twice the root");
endmodule

[hw/rtl/nearest_point_distance.sv]
// Nearest point distance: target table, query barycenter and nearest search
`timescale 1ns / 1ps
// Clear, add-target and add-node requests are accepted back to back. A finish
// request computes the barycenter with a bit-serial divider, then walks every
// stored target through the single read port of the target memory, one point
// per cycle, lets the distance pipeline drain and ends with a bit-serial square
// root. A finish on an empty table or without query nodes skips the divider,
// the scan and the square root. No further request is accepted while a finish
// is in progress. The result sits in an output register, so requests keep
// flowing while it waits; a later finish then holds in S_DONE until it is taken.
module nearest_point_distance
    import npd_pkg::*;
#(
    parameter int MAX_POINTS      = npd_pkg::MAX_POINTS_DEF,
    parameter int MAX_QUERY_NODES = npd_pkg::MAX_QUERY_NODES_DEF,
    parameter int COORD_WIDTH     = npd_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    npd_req_if.sink                    req,
    npd_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [npd_pkg::APB_AW-1:0] paddr,
    input  logic [npd_pkg::APB_DW-1:0] pwdata,
    output logic [npd_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int TCW  = $clog2(MAX_POINTS + 1);
    localparam int NCW  = $clog2(MAX_QUERY_NODES + 1);
    localparam int SUMW = CW + SUM_GUARD;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SCAN = 5'b00100,
        S_SQRT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]            dim_reg, dim_next;
    logic [TCW-1:0]        tcount_reg, tcount_next;
    logic [NCW-1:0]        ncount_reg, ncount_next;
    logic signed [SUMW-1:0] sumx_reg, sumx_next, sumy_reg, sumy_next, sumz_reg, sumz_next;
    logic                  ovf_reg, ovf_next;

    logic                  accept;
    logic                  ram_we;
    logic [3*CW-1:0]       ram_rdata;
    logic                  ram_re;

    logic                  div_start;
    logic                  div_done;
    logic signed [CW-1:0]  qx, qy, qz;
    logic signed [CW-1:0]  bx_reg, by_reg, bz_reg;

    logic [TCW-1:0]        idx_reg, idx_next;
    logic                  v1_reg, v2_reg, v3_reg;
    logic [SQW-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [SQW-1:0]        dsum_reg;
    logic [SQW-1:0]        best_reg, best_next;
    logic                  best_vld_reg, best_vld_next;
    logic signed [DW-1:0]  dx, dy, dz;
    logic [DW-1:0]         mx, my, mz;
    logic                  three_d;

    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [DW-1:0]         root;

    logic [DW-1:0]         fin_dist_reg, fin_dist_next;
    status_t               fin_status_reg, fin_status_next;
    logic                  out_vld_reg, out_vld_next;
    logic [DW-1:0]         out_dist_reg;
    status_t               out_status_reg;
    logic                  out_ovf_reg;
    logic                  out_load;

    // configuration port
    assign pready   = 1'b1;
    assign prdata   = {{(APB_DW - 2){1'b0}}, dim_reg};
    assign dim_next = (psel && penable && pwrite && (paddr == ADDR_DIMENSIONS))
                      ? pwdata[1:0] : dim_reg;
    assign three_d  = (dim_reg != DIM_2D);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign ram_we    = accept && (req.opcode == OP_ADD_TARGET)
                       && (tcount_reg != TCW'(MAX_POINTS));
    assign ram_re    = (state_reg == S_SCAN) && (idx_reg != tcount_reg);

    npd_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_targets (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tcount_reg[AW-1:0]),
        .wdata ({req.coord_z, req.coord_y, req.coord_x}),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    npd_div #(.NW(SUMW), .DW(NCW), .QW(CW)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sumx_reg),
        .divisor(ncount_reg), .done(div_done), .quotient(qx)
    );
    npd_div #(.NW(SUMW), .DW(NCW), .QW(CW)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sumy_reg),
        .divisor(ncount_reg), .done(), .quotient(qy)
    );
    npd_div #(.NW(SUMW), .DW(NCW), .QW(CW)) u_div_z (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sumz_reg),
        .divisor(ncount_reg), .done(), .quotient(qz)
    );

    npd_sqrt #(.RW(DW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (best_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    assign out_load = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);

    // control sequencer and table bookkeeping
    always_comb
    begin
        state_next      = state_reg;
        tcount_next     = tcount_reg;
        ncount_next     = ncount_reg;
        sumx_next       = sumx_reg;
        sumy_next       = sumy_reg;
        sumz_next       = sumz_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        div_start       = 1'b0;
        sqrt_start      = 1'b0;
        fin_dist_next   = fin_dist_reg;
        fin_status_next = fin_status_reg;
        best_vld_next   = best_vld_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.opcode)
                        OP_CLEAR:
                        begin
                            tcount_next = '0;
                            ovf_next    = 1'b0;
                        end
                        OP_ADD_TARGET:
                        begin
                            if (tcount_reg == TCW'(MAX_POINTS))
                                ovf_next = 1'b1;
                            else
                                tcount_next = tcount_reg + 1'b1;
                        end
                        OP_ADD_NODE:
                        begin
                            if (ncount_reg < NCW'(MAX_QUERY_NODES))
                            begin
                                sumx_next = sumx_reg
                                    + {{SUM_GUARD{req.coord_x[CW-1]}}, req.coord_x};
                                sumy_next = sumy_reg
                                    + {{SUM_GUARD{req.coord_y[CW-1]}}, req.coord_y};
                                sumz_next = sumz_reg
                                    + {{SUM_GUARD{req.coord_z[CW-1]}}, req.coord_z};
                                ncount_next = ncount_reg + 1'b1;
                            end
                        end
                        OP_FINISH:
                        begin
                            sumx_next     = '0;
                            sumy_next     = '0;
                            sumz_next     = '0;
                            ncount_next   = '0;
                            fin_dist_next = '0;
                            if (tcount_reg == '0)
                            begin
                                fin_status_next = ST_NO_TARGETS;
                                state_next      = S_DONE;
                            end
                            else if (ncount_reg == '0)
                            begin
                                fin_status_next = ST_NO_NODES;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                fin_status_next = ST_OK;
                                div_start       = 1'b1;
                                state_next      = S_DIV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                idx_next      = '0;
                best_vld_next = 1'b0;
                if (div_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (ram_re)
                    idx_next = idx_reg + 1'b1;
                if (v3_reg)
                    best_vld_next = 1'b1;
                if (!ram_re && !v1_reg && !v2_reg && !v3_reg)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    fin_dist_next = root;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // keep the smaller squared distance; ties keep the same value
    assign best_next = (v3_reg && (!best_vld_reg || dsum_reg <= best_reg))
                       ? dsum_reg : best_reg;

    // distance pipeline: difference and square, then add, then compare
    assign dx = {ram_rdata[CW-1], ram_rdata[CW-1:0]} - {bx_reg[CW-1], bx_reg};
    assign dy = {ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]} - {by_reg[CW-1], by_reg};
    assign dz = {ram_rdata[3*CW-1], ram_rdata[3*CW-1:2*CW]} - {bz_reg[CW-1], bz_reg};
    assign mx = dx[DW-1] ? (~dx + 1'b1) : dx;
    assign my = dy[DW-1] ? (~dy + 1'b1) : dy;
    assign mz = dz[DW-1] ? (~dz + 1'b1) : dz;

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            bx_reg <= qx;
            by_reg <= qy;
            bz_reg <= qz;
        end
        sqx_reg  <= mx * mx;
        sqy_reg  <= my * my;
        sqz_reg  <= three_d ? (mz * mz) : '0;
        dsum_reg <= sqx_reg + sqy_reg + sqz_reg;
        best_reg <= best_next;
        idx_reg  <= idx_next;
        fin_dist_reg   <= fin_dist_next;
        fin_status_reg <= fin_status_next;
        if (out_load)
        begin
            out_dist_reg   <= fin_dist_reg;
            out_status_reg <= fin_status_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    // hold, drop or load the result register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (rsp.valid && rsp.ready)
            out_vld_next = 1'b0;
        if (out_load)
            out_vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dim_reg      <= 2'd3;
            tcount_reg   <= '0;
            ncount_reg   <= '0;
            sumx_reg     <= '0;
            sumy_reg     <= '0;
            sumz_reg     <= '0;
            ovf_reg      <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            best_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dim_reg      <= dim_next;
            tcount_reg   <= tcount_next;
            ncount_reg   <= ncount_next;
            sumx_reg     <= sumx_next;
            sumy_reg     <= sumy_next;
            sumz_reg     <= sumz_next;
            ovf_reg      <= ovf_next;
            v1_reg       <= ram_re;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            best_vld_reg <= best_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.distance   = out_dist_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.overflowed = out_ovf_reg;

    property p_tcount_bound;
        @(posedge clk) disable iff (!rst_n) tcount_reg <= TCW'(MAX_POINTS);
    endproperty
    a_tcount_bound: assert property (p_tcount_bound)
        else $error("target count above table size");

    property p_ncount_bound;
        @(posedge clk) disable iff (!rst_n) ncount_reg <= NCW'(MAX_QUERY_NODES);
    endproperty
    a_ncount_bound: assert property (p_ncount_bound)
        else $error("query node count above limit");

    property p_scan_nonempty;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_DIV && div_done) |-> (tcount_reg != '0);
    endproperty
    a_scan_nonempty: assert property (p_scan_nonempty)
        else $error("scan started on an empty table");

    property p_pipe_empty_at_sqrt;
        @(posedge clk) disable iff (!rst_n)
            sqrt_start |-> (best_vld_reg && !v1_reg && !v2_reg && !v3_reg);
    endproperty
    a_pipe_empty_at_sqrt: assert property (p_pipe_empty_at_sqrt)
        else $error("square root started before the scan drained");
endmodule

[test/tb_nearest_point_distance.sv]
// Self-checking testbench of the nearest point distance block
`timescale 1ns / 1ps
module tb_nearest_point_distance;
    import npd_pkg::*;

    localparam int CW     = COORD_WIDTH_DEF;
    localparam int NPTS   = MAX_POINTS_DEF;
    localparam int NNODES = MAX_QUERY_NODES_DEF;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW:0] distance;
        status_t     status;
        logic        overflowed;
    } answer_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    npd_req_if #(.CW(CW)) req ();
    npd_rsp_if #(.CW(CW)) rsp ();

    nearest_point_distance dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow state of the block
    logic signed [CW-1:0] tab_x [NPTS];
    logic signed [CW-1:0] tab_y [NPTS];
    logic signed [CW-1:0] tab_z [NPTS];
    int unsigned   tab_count;
    longint        sum_x, sum_y, sum_z;
    int unsigned   node_count;
    logic          ovf_flag;
    logic [1:0]    dim_reg;

    answer_t       pending_answers [$];
    int            mismatches;
    int            hold_cycles;
    bit            allow_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned sq_abs(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0)
        begin
            d = -d;
        end
        return d * d;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // update the shadow state for one accepted request
    task automatic predict_request(opcode_t op, logic signed [CW-1:0] x,
                                   logic signed [CW-1:0] y, logic signed [CW-1:0] z);
        answer_t a;
        longint bx, by, bz, n;
        longint unsigned best, d;
        case (op)
            OP_CLEAR:
            begin
                tab_count = 0;
                ovf_flag = 1'b0;
            end
            OP_ADD_TARGET:
            begin
                if (tab_count >= NPTS)
                begin
                    ovf_flag = 1'b1;
                end
                else
                begin
                    tab_x[tab_count] = x;
                    tab_y[tab_count] = y;
                    tab_z[tab_count] = z;
                    tab_count++;
                end
            end
            OP_ADD_NODE:
            begin
                if (node_count < NNODES)
                begin
                    sum_x += x;
                    sum_y += y;
                    sum_z += z;
                    node_count++;
                end
            end
            default:
            begin
                a.distance = '0;
                a.status = ST_OK;
                if (tab_count == 0)
                begin
                    a.status = ST_NO_TARGETS;
                end
                else if (node_count == 0)
                begin
                    a.status = ST_NO_NODES;
                end
                else
                begin
                    n = node_count;
                    bx = sum_x / n;
                    by = sum_y / n;
                    bz = sum_z / n;
                    best = 0;
                    for (int i = 0; i < tab_count; i++)
                    begin
                        d = sq_abs(tab_x[i], bx) + sq_abs(tab_y[i], by);
                        if (dim_reg != DIM_2D)
                        begin
                            d += sq_abs(tab_z[i], bz);
                        end
                        if (i == 0 || d <= best)
                        begin
                            best = d;
                        end
                    end
                    a.distance = (CW + 1)'(floor_root(best));
                end
                a.overflowed = ovf_flag;
                sum_x = 0;
                sum_y = 0;
                sum_z = 0;
                node_count = 0;
                pending_answers = {pending_answers, a};
            end
        endcase
    endtask

    // send one request, with a random lead-in gap when idle gaps are allowed
    task automatic send_request(opcode_t op, logic signed [CW-1:0] x,
                                logic signed [CW-1:0] y, logic signed [CW-1:0] z);
        int gap;
        gap = allow_idle ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.opcode  <= op;
        req.coord_x <= x;
        req.coord_y <= y;
        req.coord_z <= z;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        predict_request(op, x, y, z);
    endtask

    task automatic stop_sending();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return CW'($urandom_range(0, 8191)) - CW'(4096);
            default: return CW'($urandom);
        endcase
    endfunction

    // wait for all answers, then pause before touching registers
    task automatic wait_drained();
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_dimensions(logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DIMENSIONS;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dim_reg = value;
        @(posedge clk);
    endtask

    // check each answer against the oldest prediction
    initial
    begin
        answer_t got;
        answer_t want;
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = allow_idle ? $urandom_range(0, 19) : 0;
            if ($urandom_range(0, 3) == 0)
            begin
                stall = 0;
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
            begin
                @(posedge clk);
            end
            got.distance = rsp.distance;
            got.status = rsp.status;
            got.overflowed = rsp.overflowed;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected answer dist=%0d status=%0d ovf=%0b",
                             got.distance, got.status, got.overflowed);
                end
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp dist=%0d status=%0d ovf=%0b, got dist=%0d status=%0d ovf=%0b",
                                 want.distance, want.status, want.overflowed,
                                 got.distance, got.status, got.overflowed);
                    end
                end
            end
        end
    end

    task automatic test_special_cases();
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_NODE, CMAX, CMIN, CMAX);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_TARGET, CMIN, CMIN, CMIN);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_NODE, CMAX, CMAX, CMAX);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_TARGET, CMAX, CMAX, CMAX);
        send_request(OP_ADD_NODE, CMIN, CMAX, CMIN);
        send_request(OP_ADD_NODE, CMIN, CMAX, '0);
        send_request(OP_FINISH, '0, '0, '0);
        // node sums survive a clear; the finish after it sees an empty table
        send_request(OP_ADD_NODE, 24'sd7, -24'sd7, 24'sd3);
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_TARGET, -24'sd5, 24'sd5, '0);
        send_request(OP_ADD_NODE, 24'sd1, '0, -24'sd1);
        send_request(OP_ADD_NODE, -24'sd2, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        stop_sending();
        wait_drained();
    endtask

    // exceed the node limit; barycenter of many extreme nodes
    task automatic test_node_limit();
        send_request(OP_ADD_TARGET, '0, '0, '0);
        for (int i = 0; i < NNODES + 4; i++)
        begin
            send_request(OP_ADD_NODE, (i < NNODES) ? CMIN : CMAX, CMAX, CMIN);
        end
        send_request(OP_FINISH, '0, '0, '0);
        stop_sending();
        wait_drained();
    endtask

    // fill the table beyond its size, then clear the sticky flag
    task automatic test_table_overflow();
        send_request(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < NPTS + 3; i++)
        begin
            send_request(OP_ADD_TARGET, rand_coord(), rand_coord(), rand_coord());
        end
        send_request(OP_ADD_NODE, rand_coord(), rand_coord(), rand_coord());
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_ADD_NODE, '0, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_ADD_TARGET, 24'sd1, 24'sd2, 24'sd3);
        send_request(OP_ADD_NODE, '0, '0, '0);
        send_request(OP_FINISH, '0, '0, '0);
        stop_sending();
        wait_drained();
    endtask

    // hold the answer side while finishes keep coming, so the block stalls
    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (2) @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            send_request(OP_ADD_NODE, rand_coord(), rand_coord(), rand_coord());
            send_request(OP_FINISH, '0, '0, '0);
        end
        stop_sending();
        wait_drained();
    endtask

    // random query sessions on small tables, with some noise
    task automatic test_random_queries(int n_items);
        int sent;
        int pts, nodes;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(opcode_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                             rand_coord());
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_request(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
                    sent++;
                end
                pts = $urandom_range(0, 6);
                for (int i = 0; i < pts; i++)
                begin
                    send_request(OP_ADD_TARGET, rand_coord(), rand_coord(), rand_coord());
                end
                nodes = $urandom_range(0, 5);
                for (int i = 0; i < nodes; i++)
                begin
                    send_request(OP_ADD_NODE, rand_coord(), rand_coord(), rand_coord());
                end
                send_request(OP_FINISH, rand_coord(), rand_coord(), rand_coord());
                sent += pts + nodes + 1;
            end
        end
        stop_sending();
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.opcode = OP_CLEAR;
        req.coord_x = '0;
        req.coord_y = '0;
        req.coord_z = '0;
        tab_count = 0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        node_count = 0;
        ovf_flag = 1'b0;
        dim_reg = 2'd3;
        mismatches = 0;
        hold_cycles = 0;
        allow_idle = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        write_dimensions(2'd2);
        test_special_cases();
        allow_idle = 1'b1;
        test_node_limit();
        test_table_overflow();
        test_backpressure();
        write_dimensions(2'd3);
        test_random_queries(150);
        write_dimensions(2'd2);
        test_random_queries(120);
        write_dimensions(2'd0);
        allow_idle = 1'b0;
        test_random_queries(80);
        allow_idle = 1'b1;
        write_dimensions(2'd1);
        test_random_queries(80);
        write_dimensions(2'd3);
        test_random_queries(80);

        if (mismatches == 0 && pending_answers.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[sim.f]
hw/rtl/npd_pkg.sv
hw/rtl/npd_if.sv
hw/rtl/npd_ram.sv
hw/rtl/npd_div.sv
hw/rtl/npd_sqrt.sv
hw/rtl/nearest_point_distance.sv
test/tb_nearest_point_distance.sv
